// ===== hdl/median_noise_floor_estimator_assert.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef MEDIAN_NOISE_FLOOR_ESTIMATOR_ASSERT_SVH
`define MEDIAN_NOISE_FLOOR_ESTIMATOR_ASSERT_SVH

// Same-cycle implication, gated off during reset.
`define MNFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, gated off during reset.
`define MNFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/mnfe_pkg.sv =====
package mnfe_pkg;

    localparam int HALF_SPECTRUM_BINS_DEF = 1024;
    localparam int HARMONIC_ORDERS_DEF    = 10;
    localparam int SAMPLE_CAPACITY_DEF    = 64;
    localparam int MAGNITUDE_BITS_DEF     = 24;

    localparam int BIN_W       = 10;
    localparam int STORE_DEPTH = 1024;
    localparam int MAG_W       = 24;
    localparam int CNT_W       = 7;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_W       = 10;
    // scan position: bins up to 1023 plus one stride step
    localparam int SCAN_W      = 11;

    localparam int GUARD_RADIUS      = 4;
    localparam int OUTER_RADIUS      = 32;
    localparam int MIN_LOCAL_SAMPLES = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_FIRST_BIN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LAST_BIN  = 1'b1;

    typedef enum logic {
        OP_WRITE = 1'b0,
        OP_QUERY = 1'b1
    } t_op;

    typedef struct packed {
        t_op               operation;
        logic [BIN_W-1:0]  write_bin;
        logic [MAG_W-1:0]  magnitude;
        logic [BIN_W-1:0]  centre_bin;
        logic [BIN_W-1:0]  fundamental_index;
    } t_in;

    typedef struct packed {
        logic [MAG_W-1:0]  floor_mag;
        logic [CNT_W-1:0]  samples_used;
        logic              used_fallback;
    } t_out;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HARM,
        ST_LOCAL,
        ST_LDRAIN,
        ST_DIV,
        ST_FALL,
        ST_FDRAIN,
        ST_MED,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic clear;
        logic insert;
        logic shift;
    } t_sort_ctrl;

    typedef struct packed {
        logic load;
        logic step;
    } t_harm_ctrl;

endpackage

// ===== hdl/mnfe_ram.sv =====
module mnfe_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hdl/mnfe_harm.sv =====
module mnfe_harm #(
    parameter int HALF_SPECTRUM_BINS = mnfe_pkg::HALF_SPECTRUM_BINS_DEF,
    parameter int HARMONIC_ORDERS    = mnfe_pkg::HARMONIC_ORDERS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  mnfe_pkg::t_harm_ctrl        i_ctrl,
    input  logic [mnfe_pkg::BIN_W-1:0]  i_fund,
    input  logic [mnfe_pkg::SCAN_W-1:0] i_bin,
    output logic                        o_done,
    output logic                        o_guard
);

    localparam int KW = $clog2(HARMONIC_ORDERS + 1);
    localparam int IW = $clog2(HARMONIC_ORDERS);
    localparam int AW = mnfe_pkg::BIN_W + KW;
    localparam int DW = ((AW > mnfe_pkg::SCAN_W) ? AW : mnfe_pkg::SCAN_W) + 1;

    logic [mnfe_pkg::BIN_W-1:0] r_fund;
    logic [AW-1:0]              r_acc;
    logic [KW-1:0]              r_k;
    logic [AW-1:0]              r_h  [HARMONIC_ORDERS];
    logic [HARMONIC_ORDERS-1:0] r_hv;

    // build the harmonic table one order per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= KW'(HARMONIC_ORDERS);
        end else if (i_ctrl.load) begin
            r_k <= '0;
        end else if (i_ctrl.step && !o_done) begin
            r_k <= r_k + KW'(1);
        end
        if (i_ctrl.load) begin
            r_fund <= i_fund;
            r_acc  <= AW'(i_fund);
        end else if (i_ctrl.step && !o_done) begin
            r_h[r_k[IW-1:0]]  <= r_acc;
            r_hv[r_k[IW-1:0]] <= (32'(r_acc) < 32'(HALF_SPECTRUM_BINS));
            r_acc             <= r_acc + AW'(r_fund);
        end
    end

    assign o_done = (r_k == KW'(HARMONIC_ORDERS));

    always_comb begin
        logic [DW-1:0] b;
        logic [DW-1:0] h;
        logic [DW-1:0] d;
        o_guard = 1'b0;
        b = DW'(i_bin);
        for (int k = 0; k < HARMONIC_ORDERS; k++) begin
            h = DW'(r_h[k]);
            d = (b > h) ? (b - h) : (h - b);
            if (r_hv[k] && (d <= DW'(mnfe_pkg::GUARD_RADIUS))) begin
                o_guard = 1'b1;
            end
        end
    end

endmodule

// ===== hdl/mnfe_sort.sv =====
module mnfe_sort #(
    parameter int SAMPLE_CAPACITY = mnfe_pkg::SAMPLE_CAPACITY_DEF,
    parameter int MAGNITUDE_BITS  = mnfe_pkg::MAGNITUDE_BITS_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  mnfe_pkg::t_sort_ctrl                  i_ctrl,
    input  logic [MAGNITUDE_BITS-1:0]             i_value,
    output logic [$clog2(SAMPLE_CAPACITY+1)-1:0]  o_count,
    output logic [MAGNITUDE_BITS-1:0]             o_lo,
    output logic [MAGNITUDE_BITS-1:0]             o_hi
);

    localparam int CW = $clog2(SAMPLE_CAPACITY + 1);

    logic [MAGNITUDE_BITS-1:0] r_cell [SAMPLE_CAPACITY];
    logic [MAGNITUDE_BITS-1:0] n_cell [SAMPLE_CAPACITY];
    logic [CW-1:0]             r_count;
    logic [SAMPLE_CAPACITY:0]  gt;

    // cells stay ascending; slots at or past the count act as +infinity
    always_comb begin
        gt[0] = 1'b0;
        for (int i = 0; i < SAMPLE_CAPACITY; i++) begin
            gt[i+1] = (CW'(i) >= r_count) || (r_cell[i] > i_value);
        end
        for (int i = 0; i < SAMPLE_CAPACITY; i++) begin
            n_cell[i] = r_cell[i];
            if (i_ctrl.shift) begin
                if (i < SAMPLE_CAPACITY - 1) begin
                    n_cell[i] = r_cell[(i < SAMPLE_CAPACITY - 1) ? i + 1 : i];
                end
            end else if (i_ctrl.insert && gt[i+1]) begin
                n_cell[i] = gt[i] ? r_cell[(i > 0) ? i - 1 : 0] : i_value;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clear) begin
            r_count <= '0;
        end else if (i_ctrl.insert) begin
            r_count <= r_count + CW'(1);
        end
        for (int i = 0; i < SAMPLE_CAPACITY; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    assign o_count = r_count;
    assign o_lo    = r_cell[0];
    assign o_hi    = r_cell[1];

endmodule

// ===== hdl/median_noise_floor_estimator.sv =====
// Channel  | Signals                          | Moves
// input    | i_in_valid / o_in_ready, i_in    | one write or query transaction
// output   | o_out_valid / i_out_ready, o_out | one result per query
// config   | i_cfg_we, i_cfg_idx, i_cfg_data  | register write, no wait
// A write goes straight into the spectrum RAM. A query first builds the
// harmonic table, then scans the local window (at most 65 bins) one bin per cycle,
// and when too few bins survive, forms a stride and scans the strided bins; then
// the sorted cells shift until the median reaches cell 0, and the result is
// loaded into the output register. The spectrum RAM read port sets the scan rate.
// Reset is synchronous; the spectrum RAM holds no reset value.
// A finished result waits in the output register while new writes are taken.
`include "median_noise_floor_estimator_assert.svh"

module median_noise_floor_estimator #(
    parameter int HALF_SPECTRUM_BINS = mnfe_pkg::HALF_SPECTRUM_BINS_DEF,
    parameter int HARMONIC_ORDERS    = mnfe_pkg::HARMONIC_ORDERS_DEF,
    parameter int SAMPLE_CAPACITY    = mnfe_pkg::SAMPLE_CAPACITY_DEF,
    parameter int MAGNITUDE_BITS     = mnfe_pkg::MAGNITUDE_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  mnfe_pkg::t_in                  i_in,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output mnfe_pkg::t_out                 o_out,
    input  logic                           i_cfg_we,
    input  logic [mnfe_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [mnfe_pkg::CFG_W-1:0]     i_cfg_data
);

    localparam int SW  = mnfe_pkg::SCAN_W;
    localparam int BW  = mnfe_pkg::BIN_W;
    localparam int CW  = $clog2(SAMPLE_CAPACITY + 1);
    // stride = span / SAMPLE_CAPACITY + 1, the quotient by reciprocal multiply, exact for SW-bit spans
    localparam int DIV_SH = SW + $clog2(SAMPLE_CAPACITY);
    localparam int DIV_M  = ((1 << DIV_SH) + SAMPLE_CAPACITY - 1) / SAMPLE_CAPACITY;
    localparam int MW     = SW + 2;
    localparam int PW     = SW + MW;

    mnfe_pkg::t_state     r_state, n_state;
    logic [BW-1:0]        r_first, r_last;
    logic [BW-1:0]        r_centre, n_centre;
    logic [SW-1:0]        r_bin, n_bin;
    logic [SW-1:0]        r_hi, n_hi;
    logic [SW-1:0]        r_stride, n_stride;
    logic [CW-1:0]        r_left, n_left;
    logic                 r_pend, n_pend;
    logic                 r_fb, n_fb;
    logic                 r_out_valid, n_out_valid;
    mnfe_pkg::t_out       r_out, n_out;

    logic                 in_acc, issue, ram_we;
    logic [MAGNITUDE_BITS-1:0] ram_rdata;
    mnfe_pkg::t_sort_ctrl sort_ctrl;
    mnfe_pkg::t_harm_ctrl harm_ctrl;
    logic                 harm_done, guard;
    logic [CW-1:0]        s_count;
    logic [MAGNITUDE_BITS-1:0] s_lo, s_hi;
    logic                 scan_st, local_med, out_load;

    assign in_acc = i_in_valid && o_in_ready;
    assign ram_we = in_acc && (i_in.operation == mnfe_pkg::OP_WRITE);

    mnfe_ram #(
        .WIDTH (MAGNITUDE_BITS),
        .DEPTH (mnfe_pkg::STORE_DEPTH)
    ) u_spectrum (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (i_in.write_bin),
        .i_wdata (MAGNITUDE_BITS'(i_in.magnitude)),
        .i_re    (issue),
        .i_raddr (r_bin[BW-1:0]),
        .o_rdata (ram_rdata)
    );

    mnfe_harm #(
        .HALF_SPECTRUM_BINS (HALF_SPECTRUM_BINS),
        .HARMONIC_ORDERS    (HARMONIC_ORDERS)
    ) u_harm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (harm_ctrl),
        .i_fund  (i_in.fundamental_index),
        .i_bin   (r_bin),
        .o_done  (harm_done),
        .o_guard (guard)
    );

    mnfe_sort #(
        .SAMPLE_CAPACITY (SAMPLE_CAPACITY),
        .MAGNITUDE_BITS  (MAGNITUDE_BITS)
    ) u_sort (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (sort_ctrl),
        .i_value (ram_rdata),
        .o_count (s_count),
        .o_lo    (s_lo),
        .o_hi    (s_hi)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= BW'(1);
            r_last  <= BW'(1023);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mnfe_pkg::CFG_FIRST_BIN: r_first <= i_cfg_data;
                mnfe_pkg::CFG_LAST_BIN:  r_last  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mnfe_pkg::ST_IDLE;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
        r_centre <= n_centre;
        r_bin    <= n_bin;
        r_hi     <= n_hi;
        r_stride <= n_stride;
        r_left   <= n_left;
        r_fb     <= n_fb;
        r_out    <= n_out;
    end

    always_comb begin
        logic [SW-1:0] c_ext, lo_a, hi_a, dc, span;
        logic          cand_ok, skip;
        logic [CW:0]   issued;
        logic [PW-1:0] prod;
        logic [CW-1:0] half;
        logic [MAGNITUDE_BITS:0] sum;

        n_state     = r_state;
        n_centre    = r_centre;
        n_bin       = r_bin;
        n_hi        = r_hi;
        n_stride    = r_stride;
        n_left      = r_left;
        n_fb        = r_fb;
        n_out       = r_out;
        n_pend      = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        issue       = 1'b0;
        sort_ctrl   = '0;
        harm_ctrl   = '0;
        o_in_ready  = (r_state == mnfe_pkg::ST_IDLE);

        sort_ctrl.insert = r_pend;
        issued  = (CW+1)'(s_count) + (CW+1)'(r_pend);
        cand_ok = (r_bin <= r_hi) && (issued < (CW+1)'(SAMPLE_CAPACITY));
        dc      = (r_bin > SW'(r_centre)) ? (r_bin - SW'(r_centre))
                                          : (SW'(r_centre) - r_bin);
        skip    = guard;
        c_ext   = SW'(i_in.centre_bin);
        lo_a    = (c_ext > SW'(mnfe_pkg::OUTER_RADIUS))
                  ? (c_ext - SW'(mnfe_pkg::OUTER_RADIUS)) : SW'(r_first);
        if (lo_a < SW'(r_first)) begin
            lo_a = SW'(r_first);
        end
        hi_a = c_ext + SW'(mnfe_pkg::OUTER_RADIUS);
        if (hi_a > SW'(r_last)) begin
            hi_a = SW'(r_last);
        end
        span   = SW'(r_last) - SW'(r_first) + SW'(1);
        prod   = PW'(span) * PW'(DIV_M);
        half   = s_count >> 1;
        sum    = (MAGNITUDE_BITS+1)'(s_lo) + (MAGNITUDE_BITS+1)'(s_hi);

        case (r_state)
            mnfe_pkg::ST_IDLE: begin
                if (in_acc && (i_in.operation == mnfe_pkg::OP_QUERY)) begin
                    n_centre        = i_in.centre_bin;
                    n_bin           = lo_a;
                    n_hi            = hi_a;
                    harm_ctrl.load  = 1'b1;
                    sort_ctrl.clear = 1'b1;
                    n_state         = mnfe_pkg::ST_HARM;
                end
            end
            mnfe_pkg::ST_HARM: begin
                harm_ctrl.step = 1'b1;
                if (harm_done) begin
                    n_state = mnfe_pkg::ST_LOCAL;
                end
            end
            mnfe_pkg::ST_LOCAL: begin
                if (cand_ok) begin
                    issue  = !(skip || (dc <= SW'(mnfe_pkg::GUARD_RADIUS)));
                    n_pend = issue;
                    n_bin  = r_bin + SW'(1);
                end else begin
                    n_state = mnfe_pkg::ST_LDRAIN;
                end
            end
            mnfe_pkg::ST_LDRAIN: begin
                if (!r_pend) begin
                    if (s_count < CW'(mnfe_pkg::MIN_LOCAL_SAMPLES)) begin
                        // too few local bins: restart over the whole range
                        sort_ctrl.clear = 1'b1;
                        n_fb    = 1'b1;
                        n_state = mnfe_pkg::ST_DIV;
                    end else begin
                        n_fb    = 1'b0;
                        n_state = mnfe_pkg::ST_MED;
                        n_left  = (s_count[0]) ? half : half - CW'(1);
                    end
                end
            end
            mnfe_pkg::ST_DIV: begin
                n_stride = SW'(prod >> DIV_SH) + SW'(1);
                n_bin    = SW'(r_first);
                n_hi     = SW'(r_last);
                n_state  = mnfe_pkg::ST_FALL;
            end
            mnfe_pkg::ST_FALL: begin
                if (cand_ok) begin
                    issue  = !skip;
                    n_pend = issue;
                    n_bin  = r_bin + r_stride;
                end else begin
                    n_state = mnfe_pkg::ST_FDRAIN;
                end
            end
            mnfe_pkg::ST_FDRAIN: begin
                if (!r_pend) begin
                    n_state = mnfe_pkg::ST_MED;
                    if (s_count == '0) begin
                        n_left = '0;
                    end else begin
                        n_left = (s_count[0]) ? half : half - CW'(1);
                    end
                end
            end
            mnfe_pkg::ST_MED: begin
                // advance the sorted cells until the median sits in cell 0
                if (r_left != '0) begin
                    sort_ctrl.shift = 1'b1;
                    n_left = r_left - CW'(1);
                end else begin
                    n_state = mnfe_pkg::ST_OUT;
                end
            end
            mnfe_pkg::ST_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    if (s_count == '0) begin
                        n_out.floor_mag = '0;
                    end else if (s_count[0]) begin
                        n_out.floor_mag = mnfe_pkg::MAG_W'(s_lo);
                    end else begin
                        n_out.floor_mag = mnfe_pkg::MAG_W'(sum >> 1);
                    end
                    n_out.samples_used  = mnfe_pkg::CNT_W'(s_count);
                    n_out.used_fallback = r_fb;
                    n_out_valid         = 1'b1;
                    n_state             = mnfe_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = mnfe_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign scan_st   = (r_state == mnfe_pkg::ST_LOCAL) || (r_state == mnfe_pkg::ST_LDRAIN)
                    || (r_state == mnfe_pkg::ST_FALL) || (r_state == mnfe_pkg::ST_FDRAIN);
    assign local_med = (r_state == mnfe_pkg::ST_MED) && !r_fb;
    assign out_load  = (r_state == mnfe_pkg::ST_OUT) && (!r_out_valid || i_out_ready);

    `MNFE_ASSERT_IMP(a_count_cap, i_clk, i_rst_n, 1'b1, s_count <= CW'(SAMPLE_CAPACITY), "count over cap")
    `MNFE_ASSERT_IMP(a_pend_scan, i_clk, i_rst_n, r_pend, scan_st, "read in flight outside a scan")
    `MNFE_ASSERT_IMP(a_local_min, i_clk, i_rst_n, local_med, s_count >= CW'(mnfe_pkg::MIN_LOCAL_SAMPLES), "few bins")
    `MNFE_ASSERT_NXT(a_out_load, i_clk, i_rst_n, out_load, o_out_valid && (r_state == mnfe_pkg::ST_IDLE), "no result")

endmodule

// ===== verif/median_noise_floor_estimator_tb.sv =====
`timescale 1ns / 100ps

module median_noise_floor_estimator_tb;

    class floor_scoreboard;
        logic [mnfe_pkg::MAG_W-1:0] spectrum[mnfe_pkg::STORE_DEPTH];
        int unsigned      lo_limit = 1;
        int unsigned      hi_limit = 1023;
        mnfe_pkg::t_out   floor_queue[$];
        int unsigned      errors = 0;

        function bit near_harmonic(int unsigned b, int unsigned f);
            int unsigned h;
            for (int unsigned k = 1; k <= mnfe_pkg::HARMONIC_ORDERS_DEF; k++) begin
                h = f * k;
                if (h >= mnfe_pkg::HALF_SPECTRUM_BINS_DEF) break;
                if ((b > h ? b - h : h - b) <= mnfe_pkg::GUARD_RADIUS) return 1;
            end
            return 0;
        endfunction

        function void note(mnfe_pkg::t_in it);
            int unsigned c, f, lo, hi, b, stride;
            int unsigned picks[$];
            mnfe_pkg::t_out r;
            if (it.operation == mnfe_pkg::OP_WRITE) begin
                spectrum[it.write_bin] = it.magnitude;
                return;
            end
            c  = it.centre_bin;
            f  = it.fundamental_index;
            lo = (c > mnfe_pkg::OUTER_RADIUS) ? c - mnfe_pkg::OUTER_RADIUS : lo_limit;
            hi = c + mnfe_pkg::OUTER_RADIUS;
            if (lo < lo_limit) lo = lo_limit;
            if (hi > hi_limit) hi = hi_limit;
            r.used_fallback = 1'b0;
            for (b = lo; b <= hi && picks.size() < mnfe_pkg::SAMPLE_CAPACITY_DEF; b++) begin
                if ((b > c ? b - c : c - b) <= mnfe_pkg::GUARD_RADIUS || near_harmonic(b, f))
                    continue;
                picks.push_back(spectrum[b % mnfe_pkg::STORE_DEPTH]);
            end
            if (picks.size() < mnfe_pkg::MIN_LOCAL_SAMPLES) begin
                // restart over the whole range on a stride
                picks.delete();
                r.used_fallback = 1'b1;
                stride = (hi_limit - lo_limit + 1) / mnfe_pkg::SAMPLE_CAPACITY_DEF + 1;
                for (b = lo_limit;
                     b <= hi_limit && picks.size() < mnfe_pkg::SAMPLE_CAPACITY_DEF;
                     b += stride)
                    if (!near_harmonic(b, f))
                        picks.push_back(spectrum[b % mnfe_pkg::STORE_DEPTH]);
            end
            picks.sort();
            r.samples_used = mnfe_pkg::CNT_W'(picks.size());
            if (picks.size() == 0)
                r.floor_mag = '0;
            else if (picks.size() % 2)
                r.floor_mag = mnfe_pkg::MAG_W'(picks[picks.size() / 2]);
            else
                r.floor_mag = mnfe_pkg::MAG_W'((longint'(picks[picks.size() / 2 - 1])
                                                + picks[picks.size() / 2]) >> 1);
            floor_queue.push_back(r);
        endfunction

        function void check(mnfe_pkg::t_out got);
            mnfe_pkg::t_out exp;
            if (floor_queue.size() == 0) begin
                $display("%0t: unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = floor_queue.pop_front();
            if (got.floor_mag !== exp.floor_mag) begin
                $display("%0t: floor_mag expected %0d actual %0d", $time,
                         exp.floor_mag, got.floor_mag);
                errors++;
            end
            if (got.samples_used !== exp.samples_used) begin
                $display("%0t: samples_used expected %0d actual %0d", $time,
                         exp.samples_used, got.samples_used);
                errors++;
            end
            if (got.used_fallback !== exp.used_fallback) begin
                $display("%0t: used_fallback expected %0d actual %0d", $time,
                         exp.used_fallback, got.used_fallback);
                errors++;
            end
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_in_valid = 1'b0;
    logic                           o_in_ready;
    mnfe_pkg::t_in                  i_in = '0;
    logic                           o_out_valid;
    logic                           i_out_ready = 1'b0;
    mnfe_pkg::t_out                 o_out;
    logic                           i_cfg_we = 1'b0;
    logic [mnfe_pkg::CFG_IDX_W-1:0] i_cfg_idx = mnfe_pkg::CFG_FIRST_BIN;
    logic [mnfe_pkg::CFG_W-1:0]     i_cfg_data = '0;

    floor_scoreboard sb = new();
    bit              no_gaps = 0;

    median_noise_floor_estimator i_dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(mnfe_pkg::t_in it);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in       <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note(it);
    endtask

    task automatic write_bin(int unsigned b, logic [mnfe_pkg::MAG_W-1:0] m);
        mnfe_pkg::t_in it;
        it = $bits(mnfe_pkg::t_in)'({$urandom, $urandom});
        it.operation = mnfe_pkg::OP_WRITE;
        it.write_bin = mnfe_pkg::BIN_W'(b);
        it.magnitude = m;
        send_item(it);
    endtask

    task automatic query(int unsigned c, int unsigned f);
        mnfe_pkg::t_in it;
        it = $bits(mnfe_pkg::t_in)'({$urandom, $urandom});
        it.operation         = mnfe_pkg::OP_QUERY;
        it.centre_bin        = mnfe_pkg::BIN_W'(c);
        it.fundamental_index = mnfe_pkg::BIN_W'(f);
        send_item(it);
    endtask

    // drain all results, then let the block settle before touching registers
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        wait (sb.floor_queue.size() == 0);
        repeat (300) @(posedge i_clk);
    endtask

    task automatic set_range(int unsigned first, int unsigned last);
        settle();
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= mnfe_pkg::CFG_FIRST_BIN;
        i_cfg_data <= mnfe_pkg::CFG_W'(first);
        @(negedge i_clk);
        i_cfg_idx  <= mnfe_pkg::CFG_LAST_BIN;
        i_cfg_data <= mnfe_pkg::CFG_W'(last);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.lo_limit = first;
        sb.hi_limit = last;
    endtask

    function logic [mnfe_pkg::MAG_W-1:0] rand_mag();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return mnfe_pkg::MAG_W'($urandom_range(0, 15));
            default: return mnfe_pkg::MAG_W'($urandom);
        endcase
    endfunction

    task automatic random_phase(int unsigned count);
        for (int unsigned i = 0; i < count; i++) begin
            no_gaps = (i % 64) < 12;
            if ($urandom_range(0, 99) < 55)
                write_bin($urandom_range(0, 1023), rand_mag());
            else if ($urandom_range(0, 3) == 0)
                query($urandom_range(0, 1023), $urandom_range(0, 1023));
            else
                query($urandom_range(0, 1023), $urandom_range(0, 110));
        end
        no_gaps = 0;
    endtask

    // output side: random backpressure
    initial begin
        int unsigned gap;
        forever begin
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
    end

    always @(posedge i_clk)
        if (i_rst_n && o_out_valid && i_out_ready) sb.check(o_out);

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        // fill every bin so no query reads an unwritten entry
        for (int unsigned b = 0; b < mnfe_pkg::STORE_DEPTH; b++) write_bin(b, rand_mag());
        write_bin(0, '0);
        write_bin(1023, '1);
        query(0, 0);
        query(1023, 1023);
        query(32, 1);
        query(33, 7);
        query(500, 0);
        query(100, 100);
        query(512, 50);
        set_range(1, 1023);
        query(10, 3);
        query(1023, 1);
        set_range(1023, 1023);
        query(1023, 0);
        query(0, 5);
        set_range(1, 1);
        query(1, 0);
        query(40, 40);
        set_range(600, 400);
        query(500, 9);
        query(0, 1023);
        set_range(1000, 1023);
        query(1010, 3);
        random_phase(50);
        set_range(1, 1023);
        random_phase(60);
        set_range(1, 60);
        random_phase(40);
        set_range($urandom_range(1, 511), $urandom_range(512, 1023));
        random_phase(38);
        set_range(1023, 1);
        random_phase(20);
        settle();
        if (sb.errors == 0 && sb.floor_queue.size() == 0)
            $display("median_noise_floor_estimator verification clean");
        else
            $display("median_noise_floor_estimator verification failed");
        $finish;
    end

    initial begin
        #50_000_000;
        $display("median_noise_floor_estimator verification failed");
        $finish;
    end
endmodule
